@@ hw/rtl/sensor_pulse_width_classifier_defines.svh @@
// ----------------------------------------------------------------------------
// Sensor pulse width classifier: assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SENSOR_PULSE_WIDTH_CLASSIFIER_DEFINES_SVH
`define SENSOR_PULSE_WIDTH_CLASSIFIER_DEFINES_SVH

`ifndef SYNTH

// Check prop on every rising edge of ck while rn is high.
`define SPWC_ASSERT_CK(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Same check, on the block's own clock and reset.
`define SPWC_ASSERT(lbl, prop, msg) \
	`SPWC_ASSERT_CK(lbl, clk, arst_n, prop, msg)

`else

`define SPWC_ASSERT_CK(lbl, ck, rn, prop, msg)
`define SPWC_ASSERT(lbl, prop, msg)

`endif

`endif

@@ hw/rtl/spwc_pkg.sv @@
// ----------------------------------------------------------------------------
// Sensor pulse width classifier: package
// Widths, register map, phase encoding and the shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package spwc_pkg;

	localparam int TIMER_BITS  = 20;
	localparam int COUNT_BITS  = 16;
	localparam int QUAL_BITS   = 16;
	localparam int GLITCH_BITS = 32;
	localparam int CFG_BITS    = 16;
	localparam int FIELD_BITS  = 16;

	// Scaled timer: 5 * elapsed needs three more bits
	localparam int SCALED_BITS = TIMER_BITS + 3;

	// Shortest pulse that counts toward the glitch total
	localparam logic [QUAL_BITS-1:0] GLITCH_MIN = QUAL_BITS'(2);

	// APB register map
	localparam int DATA_BITS = 32;
	localparam int ADDR_BITS = 3;
	localparam logic REG_QUALIFY = 1'b0;
	localparam logic REG_NOMINAL = 1'b1;

	localparam logic [CFG_BITS-1:0] QUALIFY_RESET = CFG_BITS'(10);
	localparam logic [CFG_BITS-1:0] NOMINAL_RESET = CFG_BITS'(100);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_QUAL = 2'd1,
		PH_TRIG = 2'd2,
		PH_MEAS = 2'd3
	} phase_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] qualify_ticks;
		logic [CFG_BITS-1:0] nominal_width;
	} cfg_t;

	typedef struct packed {
		phase_t                 phase;
		logic                   trigger;
		logic                   finished;
		logic                   is_long;
		logic [FIELD_BITS-1:0]  detections;
		logic [FIELD_BITS-1:0]  long_objects;
		logic [GLITCH_BITS-1:0] glitch_ticks;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/spwc_regs.sv @@
// ----------------------------------------------------------------------------
// Sensor pulse width classifier: configuration registers
// APB-style write/read access to qualify_ticks and nominal_width.
// ----------------------------------------------------------------------------
`default_nettype none

module spwc_regs import spwc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [DATA_BITS-1:0] pwdata,
	output logic      [DATA_BITS-1:0] prdata,
	output logic                      pready,
	output cfg_t                      cfg
);

	logic [CFG_BITS-1:0] qualify_q;
	logic [CFG_BITS-1:0] nominal_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qualify_q <= QUALIFY_RESET;
			nominal_q <= NOMINAL_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_QUALIFY: qualify_q <= pwdata[CFG_BITS-1:0];
				REG_NOMINAL: nominal_q <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_QUALIFY: prdata = DATA_BITS'(qualify_q);
			REG_NOMINAL: prdata = DATA_BITS'(nominal_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg.qualify_ticks = qualify_q;
	assign cfg.nominal_width = nominal_q;

endmodule

`default_nettype wire

@@ hw/rtl/spwc_core.sv @@
// ----------------------------------------------------------------------------
// Sensor pulse width classifier: phase machine and counters
// Steps the phase, qualify count, timer and statistics once per sample.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sensor_pulse_width_classifier_defines.svh"

module spwc_core import spwc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step_en,
	input  wire logic active,
	input  cfg_t      cfg,
	output result_t   res
);

	phase_t                 phase_q,   phase_n;
	logic [QUAL_BITS-1:0]   qual_q,    qual_n,    qual_inc;
	logic [TIMER_BITS-1:0]  elapsed_q, elapsed_n, elapsed_inc;
	logic [COUNT_BITS-1:0]  det_q,     det_n;
	logic [COUNT_BITS-1:0]  long_q,    long_n;
	logic [GLITCH_BITS-1:0] glitch_q,  glitch_n;
	logic [SCALED_BITS-1:0] elapsed_x5, nominal_x4, nominal_x6;
	logic                   trig, fin, lng;

	assign qual_inc    = (qual_q != '1) ? qual_q + QUAL_BITS'(1) : qual_q;
	assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + TIMER_BITS'(1) : elapsed_q;

	// Thresholds at 0.8x and 1.2x nominal, compared as 5*t against 4*n and 6*n
	assign elapsed_x5 = (SCALED_BITS'(elapsed_inc) << 2) + SCALED_BITS'(elapsed_inc);
	assign nominal_x4 = SCALED_BITS'(cfg.nominal_width) << 2;
	assign nominal_x6 = (SCALED_BITS'(cfg.nominal_width) << 2)
		+ (SCALED_BITS'(cfg.nominal_width) << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			qual_q    <= '0;
			elapsed_q <= '0;
			det_q     <= '0;
			long_q    <= '0;
			glitch_q  <= '0;
		end else if (step_en) begin
			phase_q   <= phase_n;
			qual_q    <= qual_n;
			elapsed_q <= elapsed_n;
			det_q     <= det_n;
			long_q    <= long_n;
			glitch_q  <= glitch_n;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		qual_n    = qual_q;
		elapsed_n = elapsed_q;
		det_n     = det_q;
		long_n    = long_q;
		glitch_n  = glitch_q;
		trig      = 1'b0;
		fin       = 1'b0;
		lng       = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (active) begin
					phase_n = PH_QUAL;
					qual_n  = '0;
				end
			end
			PH_QUAL: begin
				qual_n = qual_inc;
				if (qual_inc >= cfg.qualify_ticks) begin
					phase_n = PH_TRIG;
				end else if (!active) begin
					phase_n = PH_IDLE;
					if (qual_inc >= GLITCH_MIN) begin
						glitch_n = glitch_q + GLITCH_BITS'(qual_inc);
					end
				end
			end
			PH_TRIG: begin
				det_n     = det_q + COUNT_BITS'(1);
				trig      = 1'b1;
				elapsed_n = '0;
				qual_n    = '0;
				phase_n   = PH_MEAS;
			end
			PH_MEAS: begin
				elapsed_n = elapsed_inc;
				if (!active && (elapsed_x5 > nominal_x4)) begin
					phase_n = PH_IDLE;
					fin     = 1'b1;
					if (elapsed_x5 > nominal_x6) begin
						lng    = 1'b1;
						long_n = long_q + COUNT_BITS'(1);
					end
				end
			end
			default: phase_n = PH_IDLE;
		endcase
	end

	assign res.phase        = phase_n;
	assign res.trigger      = trig;
	assign res.finished     = fin;
	assign res.is_long      = lng;
	assign res.detections   = FIELD_BITS'(det_n);
	assign res.long_objects = FIELD_BITS'(long_n);
	assign res.glitch_ticks = glitch_n;

	`SPWC_ASSERT(a_trig_to_meas, (step_en && phase_q == PH_TRIG) |=> (phase_q == PH_MEAS), "triggered phase did not move to measuring")
	`SPWC_ASSERT(a_det_step, (step_en && phase_q == PH_TRIG) |=> ((det_q - $past(det_q)) == COUNT_BITS'(1)), "detection count did not advance by one")
	`SPWC_ASSERT(a_hold_idle, !step_en |=> ($stable(phase_q) && $stable(glitch_q) && $stable(long_q)), "state changed without a sample")
	`SPWC_ASSERT(a_long_fin, (res.is_long |-> res.finished) && !(res.trigger && res.finished), "inconsistent result flags")
	`SPWC_ASSERT(a_fin_from_meas, res.finished |-> (phase_q == PH_MEAS && !active), "object ended outside measuring")

endmodule

`default_nettype wire

@@ hw/rtl/sensor_pulse_width_classifier.sv @@
// ----------------------------------------------------------------------------
// Sensor pulse width classifier: top level
// Classifies presence-sensor pulses into glitches, normal and long objects.
// ----------------------------------------------------------------------------
// Each sample request yields exactly one result request. A sample is captured
// in an input register, the phase machine classifies it in one pass of short
// logic, and the result lands in an output register: throughput is one sample
// per cycle while in_stall is low, and the next sample is taken while a
// result waits. A stall on the output holds both registers, so in_stall rises
// only when a captured sample has nowhere to go. Phases: 0 idle,
// 1 qualifying, 2 triggered, 3 measuring. The sensor must stay active for
// qualify_ticks samples before a detection triggers; the object then ends on
// an inactive sample once the timer exceeds 0.8x nominal_width, and it is
// long beyond 1.2x. The timer saturates at 2^20-1, detection and long counts
// wrap at 16 bits and the glitch total at 32 bits. Registers: qualify_ticks
// at byte address 0 and nominal_width at 4, written only while no sample is
// in flight: a rule for the user that the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_pulse_width_classifier import spwc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// APB configuration port
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [ADDR_BITS-1:0]   paddr,
	input  wire logic [DATA_BITS-1:0]   pwdata,
	output logic      [DATA_BITS-1:0]   prdata,
	output logic                        pready,
	// sample channel
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   sensor_active,
	// result channel
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic      [1:0]             phase,
	output logic                        trigger,
	output logic                        finished,
	output logic                        is_long,
	output logic      [FIELD_BITS-1:0]  detections,
	output logic      [FIELD_BITS-1:0]  long_objects,
	output logic      [GLITCH_BITS-1:0] glitch_ticks
);

	cfg_t    cfg;
	result_t res;
	result_t res_q;
	logic    valid_s1;
	logic    active_s1;
	logic    out_valid_q;
	logic    advance;
	logic    step_en;
	logic    accept;

	spwc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance whenever the output register is empty or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign step_en  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Input register: hold the sample until the phase machine consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			active_s1 <= sensor_active;
		end
	end

	// Classify the captured sample and step the state
	spwc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.active  (active_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Output register: drop the old result as soon as it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign phase        = res_q.phase;
	assign trigger      = res_q.trigger;
	assign finished     = res_q.finished;
	assign is_long      = res_q.is_long;
	assign detections   = res_q.detections;
	assign long_objects = res_q.long_objects;
	assign glitch_ticks = res_q.glitch_ticks;

endmodule

`default_nettype wire

@@ tb/spwc_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor pulse width classifier: result checker
// Watches the sample, result and APB channels, predicts each result from
// its own copy of the phase machine and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module spwc_result_checker import spwc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic                   pready,
	input  wire logic [ADDR_BITS-1:0]   paddr,
	input  wire logic [DATA_BITS-1:0]   pwdata,
	input  wire logic                   in_valid,
	input  wire logic                   in_stall,
	input  wire logic                   sensor_active,
	input  wire logic                   out_valid,
	input  wire logic                   out_stall,
	input  wire logic [1:0]             phase,
	input  wire logic                   trigger,
	input  wire logic                   finished,
	input  wire logic                   is_long,
	input  wire logic [FIELD_BITS-1:0]  detections,
	input  wire logic [FIELD_BITS-1:0]  long_objects,
	input  wire logic [GLITCH_BITS-1:0] glitch_ticks,
	output int                          faults,
	output int                          owed
);

	// thresholds: 5*elapsed against 4x and 6x nominal
	localparam int TICK_SCALE = 5;
	localparam int END_SCALE  = 4;
	localparam int LONG_SCALE = 6;

	phase_t                 cur_phase;
	logic [QUAL_BITS-1:0]   qual_run;
	logic [TIMER_BITS-1:0]  meas_ticks;
	logic [COUNT_BITS-1:0]  det_total;
	logic [COUNT_BITS-1:0]  long_total;
	logic [GLITCH_BITS-1:0] glitch_sum;
	logic [CFG_BITS-1:0]    qualify_cfg;
	logic [CFG_BITS-1:0]    nominal_cfg;

	result_t sample_verdicts[$];

	// advance the phase machine by one sample and return what it reports
	function automatic result_t classify_sample(logic active);
		result_t                r;
		logic [SCALED_BITS:0]   scaled;
		logic [SCALED_BITS:0]   end_bound;
		logic [SCALED_BITS:0]   long_bound;
		r = '0;
		case (cur_phase)
			PH_IDLE: begin
				if (active) begin
					cur_phase = PH_QUAL;
					qual_run  = '0;
				end
			end
			PH_QUAL: begin
				if (qual_run != '1)
					qual_run = qual_run + 1'b1;
				if (qual_run >= qualify_cfg) begin
					cur_phase = PH_TRIG;
				end else if (!active) begin
					cur_phase = PH_IDLE;
					if (qual_run >= GLITCH_MIN)
						glitch_sum = glitch_sum + qual_run;
				end
			end
			PH_TRIG: begin
				det_total  = det_total + 1'b1;
				r.trigger  = 1'b1;
				meas_ticks = '0;
				qual_run   = '0;
				cur_phase  = PH_MEAS;
			end
			default: begin
				if (meas_ticks != '1)
					meas_ticks = meas_ticks + 1'b1;
				scaled     = meas_ticks;
				scaled     = scaled * TICK_SCALE;
				end_bound  = nominal_cfg;
				end_bound  = end_bound * END_SCALE;
				long_bound = nominal_cfg;
				long_bound = long_bound * LONG_SCALE;
				if (!active && scaled > end_bound) begin
					cur_phase  = PH_IDLE;
					r.finished = 1'b1;
					if (scaled > long_bound) begin
						r.is_long  = 1'b1;
						long_total = long_total + 1'b1;
					end
				end
			end
		endcase
		r.phase        = cur_phase;
		r.detections   = FIELD_BITS'(det_total);
		r.long_objects = FIELD_BITS'(long_total);
		r.glitch_ticks = glitch_sum;
		return r;
	endfunction

	function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			cur_phase   = PH_IDLE;
			qual_run    = '0;
			meas_ticks  = '0;
			det_total   = '0;
			long_total  = '0;
			glitch_sum  = '0;
			qualify_cfg = QUALIFY_RESET;
			nominal_cfg = NOMINAL_RESET;
			sample_verdicts.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_BITS-1:2])
					REG_QUALIFY: qualify_cfg = pwdata[CFG_BITS-1:0];
					REG_NOMINAL: nominal_cfg = pwdata[CFG_BITS-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got.phase        = phase_t'(phase);
				got.trigger      = trigger;
				got.finished     = finished;
				got.is_long      = is_long;
				got.detections   = detections;
				got.long_objects = long_objects;
				got.glitch_ticks = glitch_ticks;
				if (sample_verdicts.size() == 0) begin
					$error("result arrived with no sample outstanding");
					faults = faults + 1;
				end else begin
					want   = sample_verdicts.pop_front();
					faults = faults
						+ field_diff("phase", want.phase, got.phase)
						+ field_diff("trigger", want.trigger, got.trigger)
						+ field_diff("finished", want.finished, got.finished)
						+ field_diff("is_long", want.is_long, got.is_long)
						+ field_diff("detections", want.detections, got.detections)
						+ field_diff("long_objects", want.long_objects, got.long_objects)
						+ field_diff("glitch_ticks", want.glitch_ticks, got.glitch_ticks);
				end
			end
			if (in_valid && !in_stall)
				sample_verdicts.insert(sample_verdicts.size(),
					classify_sample(sensor_active));
		end
		owed = sample_verdicts.size();
	end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor pulse width classifier: testbench top
// Drives sample requests and APB writes, stalls the result channel, and
// leaves prediction and comparison to the result checker beside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import spwc_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int TIMEOUT_NS    = 2_000_000;
	localparam int DRAIN_CYCLES  = 4;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 1440;
	localparam int RANDOM_PHASES = 6;
	localparam int CFG_MAX       = 65535;

	logic clk;
	logic arst_n;

	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_BITS-1:0]   paddr;
	logic [DATA_BITS-1:0]   pwdata;
	logic [DATA_BITS-1:0]   prdata;
	logic                   pready;

	logic                   in_valid;
	logic                   in_stall;
	logic                   sensor_active;

	logic                   out_valid;
	logic                   out_stall;
	logic [1:0]             phase;
	logic                   trigger;
	logic                   finished;
	logic                   is_long;
	logic [FIELD_BITS-1:0]  detections;
	logic [FIELD_BITS-1:0]  long_objects;
	logic [GLITCH_BITS-1:0] glitch_ticks;

	int faults;
	int owed;

	// Handshake flags, sampled with the pre-edge values at each rising edge
	logic in_taken;
	logic apb_taken;

	// Stimulus bookkeeping
	int burst_left;
	bit hold_req;
	int qual_setting;
	int nom_setting;

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	sensor_pulse_width_classifier u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sensor_active(sensor_active),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.phase        (phase),
		.trigger      (trigger),
		.finished     (finished),
		.is_long      (is_long),
		.detections   (detections),
		.long_objects (long_objects),
		.glitch_ticks (glitch_ticks)
	);

	spwc_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sensor_active(sensor_active),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.phase        (phase),
		.trigger      (trigger),
		.finished     (finished),
		.is_long      (is_long),
		.detections   (detections),
		.long_objects (long_objects),
		.glitch_ticks (glitch_ticks),
		.faults       (faults),
		.owed         (owed)
	);

	always @(posedge clk) begin
		in_taken  <= in_valid && !in_stall;
		apb_taken <= psel && penable && pwrite && pready;
	end

	// Offer one sample request and hold it until the block takes it. Bursts
	// of random length are separated by random gaps.
	task automatic send_sample(input logic s);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 7);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			if ($urandom_range(0, 7) == 0)
				burst_left = 200;
			else
				burst_left = $urandom_range(1, 24);
		end
		in_valid      <= 1'b1;
		sensor_active <= s;
		do @(negedge clk); while (!in_taken);
		burst_left = burst_left - 1;
	endtask

	// Send count samples, most significant bit of the pattern first
	task automatic send_pattern(input logic [31:0] bits, input int count);
		int i;
		for (i = count - 1; i >= 0; i--)
			send_sample(bits[i]);
	endtask

	// Drop valid, let every outstanding result come back, then wait out
	// the block's latency so nothing is left in flight.
	task automatic settle();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (owed != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Setup cycle, access cycle, then release the bus so the next write starts
	// from a clean step.
	task automatic apb_write(input logic reg_idx, input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!apb_taken);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input int qual, input int nom);
		settle();
		apb_write(REG_QUALIFY, qual);
		apb_write(REG_NOMINAL, nom);
		qual_setting = qual;
		nom_setting  = nom;
	endtask

	// Random part: mostly well-formed pulses (glitches no longer than the
	// qualify window, objects whose measured length lands near the 0.8x and
	// 1.2x thresholds), with some raw noise and some pulses broken by a
	// single dropped sample.
	task automatic run_random(input int budget);
		int sent;
		int qeff;
		int a_len;
		int b_len;
		int m;
		int lo;
		int hi;
		int pos;
		int i;
		bit broken;
		qeff = (qual_setting == 0) ? 1 : qual_setting;
		lo   = (4 * nom_setting) / 5;
		hi   = (6 * nom_setting) / 5;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 9) < 2) begin
				a_len = $urandom_range(1, 8);
				for (i = 0; i < a_len; i++)
					send_sample($urandom_range(0, 1));
				sent += a_len;
			end else begin
				if ($urandom_range(0, 9) < 4 || qeff > 64) begin
					// glitch: no longer than the qualify window
					a_len = $urandom_range(1, (qeff > 300) ? 300 : qeff);
				end else begin
					// object: idle entry, qualify window, trigger tick, then m
					// active measuring ticks
					case ($urandom_range(0, 3))
						0:       m = $urandom_range(0, lo + 1);
						1:       m = lo + $urandom_range(0, 2);
						2:       m = hi + $urandom_range(0, 2);
						default: m = $urandom_range(0, 2 * nom_setting + 3);
					endcase
					a_len = qeff + 2 + m;
				end
				if ($urandom_range(0, 3) == 0)
					b_len = $urandom_range(1, nom_setting + 4);
				else
					b_len = $urandom_range(1, 3);
				broken = ($urandom_range(0, 9) == 0);
				pos    = $urandom_range(0, a_len - 1);
				for (i = 0; i < a_len; i++)
					send_sample(!(broken && i == pos));
				repeat (b_len) send_sample(1'b0);
				sent += a_len + b_len;
			end
		end
	endtask

	// Receiver: stall on a pattern of its own. Each stretch picks a mode:
	// free flowing, coin flip, light stalls or heavy stalls. A hold-off
	// request makes it stall once for a long counted stretch so the block
	// fills and pushes back on the sample channel.
	initial begin : receiver
		int mode;
		int run_len;
		int held;
		bit hold_done;
		out_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				for (held = 0; held < HOLD_CYCLES; held++) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
				hold_done = 1'b1;
			end else begin
				mode    = $urandom_range(0, 3);
				run_len = $urandom_range(1, 40);
				repeat (run_len) begin
					case (mode)
						0:       out_stall <= 1'b0;
						1:       out_stall <= $urandom_range(0, 1);
						2:       out_stall <= ($urandom_range(0, 3) == 0);
						default: out_stall <= ($urandom_range(0, 3) != 0);
					endcase
					@(negedge clk);
				end
			end
		end
	end

	// Hard stop in case the block hangs or drops results
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("tb failed");
		$finish;
	end

	initial begin : stimulus
		int rand_qual [RANDOM_PHASES];
		int rand_nom  [RANDOM_PHASES];
		int p;
		rand_qual = '{1, 4, 2, 0, CFG_MAX, 5};
		rand_nom  = '{3, 10, 1, 7, 5, 0};

		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		sensor_active = 1'b0;
		burst_left    = 0;
		hold_req      = 1'b0;
		qual_setting  = QUALIFY_RESET;
		nom_setting   = NOMINAL_RESET;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: one idle tick, then a three-tick glitch that counts
		send_pattern(32'b01110, 5);

		// Qualify 3, nominal 1: a one-tick glitch that does not count, a
		// two-tick glitch that does, a trigger reached on an inactive sample
		// followed by a normal end at the first measuring tick, and an object
		// that ends long on its second measuring tick.
		set_config(3, 1);
		send_pattern(32'b10_110_111000_1111110, 18);

		// Zero registers: qualify acts like 1, the first inactive measuring
		// sample ends the object and it is long.
		set_config(0, 0);
		send_pattern(32'b1100, 4);

		// Random phases; the first one carries the long receiver hold-off
		for (p = 0; p < RANDOM_PHASES; p++) begin
			set_config(rand_qual[p], rand_nom[p]);
			if (p == 0)
				hold_req = 1'b1;
			run_random(RANDOM_ITEMS / RANDOM_PHASES);
		end

		settle();
		if (faults == 0 && owed == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

`default_nettype wire
